// ===== rtl/core/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types and constants for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned CapW   = 5;

  localparam logic ActGet = 1'b0;
  localparam logic ActPut = 1'b1;

  localparam logic [ValW-1:0]   MissValue = '1;
  localparam logic [CountW-1:0] CountMax  = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic lookup;   // Register the request and run the key match.
    logic apply;    // Apply the update decided from the lookup results.
  } lfu_cmd_t;

endpackage

// ===== rtl/core/lfu_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache stream interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic signed [lfu_pkg::KeyW-1:0] key;
  logic signed [lfu_pkg::ValW-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic signed [lfu_pkg::ValW-1:0] read_value;
  logic                            evicted;
  logic signed [lfu_pkg::KeyW-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== rtl/core/lfu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences one request: accept, look up, update, then present the response.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output lfu_pkg::lfu_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StApply,
    StResp
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (req_valid_i) state_d = StLookup;
      StLookup: state_d = StApply;
      StApply:  state_d = StResp;
      StResp:   if (rsp_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o  = (state_q == StIdle);
  assign rsp_valid_o  = (state_q == StResp);
  assign cmd_o.lookup = (state_q == StIdle) && req_valid_i;
  assign cmd_o.apply  = (state_q == StApply);

endmodule

// ===== rtl/core/lfu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry registers, key match, victim search and the rank/count update.
// ----------------------------------------------------------------------------
module lfu_datapath #(
  parameter int unsigned Entries = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfu_pkg::lfu_cmd_t                 cmd_i,
  input  logic [lfu_pkg::CapW-1:0]          capacity_i,
  input  logic                              action_i,
  input  logic [lfu_pkg::KeyW-1:0]          key_i,
  input  logic [lfu_pkg::ValW-1:0]          value_i,
  output logic                              hit_o,
  output logic [lfu_pkg::ValW-1:0]          read_value_o,
  output logic                              evicted_o,
  output logic [lfu_pkg::KeyW-1:0]          evicted_key_o
);

  localparam int unsigned IdxW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW   = $clog2(Entries + 1);
  localparam int unsigned CountW = lfu_pkg::CountW;
  localparam int unsigned Leaves = 1 << IdxW;
  localparam int unsigned Nodes  = 2 * Leaves - 1;

  logic [Entries-1:0]                valid_q;
  logic [lfu_pkg::KeyW-1:0]          key_q   [Entries];
  logic [lfu_pkg::ValW-1:0]          val_q   [Entries];
  logic [lfu_pkg::CountW-1:0]        use_q   [Entries];
  logic [IdxW-1:0]                   rank_q  [Entries];
  logic [CntW-1:0]                   count_q;

  // Request registers.
  logic                     act_q;
  logic [lfu_pkg::KeyW-1:0] rkey_q;
  logic [lfu_pkg::ValW-1:0] rval_q;

  // Lookup results, registered for the apply step.
  logic                     hit_q;
  logic [IdxW-1:0]          hidx_q;
  logic                     vfound_q;
  logic [IdxW-1:0]          vidx_q;
  logic                     free_q;
  logic [IdxW-1:0]          fidx_q;

  logic                     hit_o_q, ev_o_q;
  logic [lfu_pkg::ValW-1:0] rd_o_q;
  logic [lfu_pkg::KeyW-1:0] evk_o_q;

  // Key match and free-slot search are priority picks over the entry
  // registers. The victim is the minimum of {count, rank} over the valid
  // entries, found by a balanced compare tree.
  logic                     m_hit;
  logic [IdxW-1:0]          m_idx;
  logic                     v_found;
  logic [IdxW-1:0]          v_idx;
  logic                     f_found;
  logic [IdxW-1:0]          f_idx;

  logic                     t_ok  [Nodes];
  logic [CountW+IdxW-1:0]   t_key [Nodes];
  logic [IdxW-1:0]          t_idx [Nodes];
  logic                     t_left;

  always_comb begin
    m_hit   = 1'b0;
    m_idx   = '0;
    f_found = 1'b0;
    f_idx   = '0;
    for (int i = 0; i < Entries; i++) begin
      if (valid_q[i] && key_q[i] == rkey_q && !m_hit) begin
        m_hit = 1'b1;
        m_idx = IdxW'(i);
      end
      if (!valid_q[i] && !f_found) begin
        f_found = 1'b1;
        f_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    t_left = 1'b0;
    for (int n = 0; n < Leaves; n++) begin
      if (n < Entries) begin
        t_ok[Leaves-1+n]  = valid_q[n];
        t_key[Leaves-1+n] = {use_q[n], rank_q[n]};
      end else begin
        t_ok[Leaves-1+n]  = 1'b0;
        t_key[Leaves-1+n] = '0;
      end
      t_idx[Leaves-1+n] = IdxW'(n);
    end
    // Ranks of valid entries are distinct, so the minimum is unique.
    for (int n = int'(Leaves) - 2; n >= 0; n--) begin
      t_left   = t_ok[2*n+1] && (!t_ok[2*n+2] || t_key[2*n+1] <= t_key[2*n+2]);
      t_ok[n]  = t_ok[2*n+1] || t_ok[2*n+2];
      t_key[n] = t_left ? t_key[2*n+1] : t_key[2*n+2];
      t_idx[n] = t_left ? t_idx[2*n+1] : t_idx[2*n+2];
    end
    v_found = t_ok[0];
    v_idx   = t_idx[0];
  end

  logic [CntW-1:0] cap_eff;
  always_comb begin
    if (32'(capacity_i) > Entries) cap_eff = CntW'(Entries);
    else                           cap_eff = CntW'(capacity_i);
  end

  // Apply-step decisions.
  logic            do_promote, do_insert, do_evict, cap_ok;
  logic [IdxW-1:0] p_idx, ins_idx;
  logic [IdxW-1:0] p_rank, v_rank;
  always_comb begin
    cap_ok     = (cap_eff != '0);
    do_promote = hit_q && (act_q == lfu_pkg::ActGet || cap_ok);
    do_evict   = (act_q == lfu_pkg::ActPut) && cap_ok && !hit_q &&
                 (count_q >= cap_eff) && vfound_q;
    do_insert  = (act_q == lfu_pkg::ActPut) && cap_ok && !hit_q && (do_evict || free_q);
    p_idx      = hidx_q;
    ins_idx    = do_evict ? vidx_q : fidx_q;
    p_rank     = rank_q[hidx_q];
    v_rank     = rank_q[vidx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.apply) begin
      if (do_insert) begin
        valid_q[ins_idx] <= 1'b1;
        // An eviction and an insert leave the count unchanged.
        if (!do_evict) count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      act_q  <= action_i;
      rkey_q <= key_i;
      rval_q <= value_i;
    end
    // Lookup results register in the cycle after the request registers load.
    hit_q    <= m_hit;
    hidx_q   <= m_idx;
    vfound_q <= v_found;
    vidx_q   <= v_idx;
    free_q   <= f_found;
    fidx_q   <= f_idx;
    if (cmd_i.apply) begin
      for (int i = 0; i < Entries; i++) begin
        if (do_promote && valid_q[i] && rank_q[i] > p_rank) rank_q[i] <= rank_q[i] - 1'b1;
        if (do_evict && valid_q[i] && rank_q[i] > v_rank) rank_q[i] <= rank_q[i] - 1'b1;
      end
      if (do_promote) begin
        rank_q[p_idx] <= IdxW'(count_q - 1'b1);
        if (use_q[p_idx] != lfu_pkg::CountMax) use_q[p_idx] <= use_q[p_idx] + 1'b1;
        if (act_q == lfu_pkg::ActPut) val_q[p_idx] <= rval_q;
      end
      if (do_insert) begin
        key_q[ins_idx]  <= rkey_q;
        val_q[ins_idx]  <= rval_q;
        use_q[ins_idx]  <= CountW'(1);
        // After an eviction the new entry takes the newest rank, count-1.
        rank_q[ins_idx] <= do_evict ? IdxW'(count_q - 1'b1) : IdxW'(count_q);
      end
      hit_o_q <= hit_q;
      ev_o_q  <= do_evict;
      evk_o_q <= do_evict ? key_q[vidx_q] : '0;
      if (act_q == lfu_pkg::ActGet) rd_o_q <= hit_q ? val_q[hidx_q] : lfu_pkg::MissValue;
      else                          rd_o_q <= '0;
    end
  end

  assign hit_o         = hit_o_q;
  assign read_value_o  = rd_o_q;
  assign evicted_o     = ev_o_q;
  assign evicted_key_o = evk_o_q;

endmodule

// ===== rtl/core/lfu_cache_with_lru_tiebreak.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Key-value cache with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Requests arrive on req (action, key, value); one response per request
// leaves on rsp (hit, read_value, evicted, evicted_key). A get hit raises
// the entry's use count and makes it newest; a put inserts or updates, and
// evicts the least used, oldest entry when the cache is full.
// capacity is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while the block is idle, as the block does no check of this.
// The accepting edge registers the request. In the lookup state the parallel
// key match and the minimum search over all entries run and their results
// are registered, the apply state applies the update, and rsp is then valid.
// The controller handles one request at a time, so a new request is taken
// only after the response has transferred, and receiver stalls hold it off.
// Reset empties the cache and sets capacity to 16. While rsp is stalled
// the response holds and req stays not ready.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak #(
  parameter int unsigned Entries = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0]   cfg_wdata_i,
  lfu_req_if.sink                    req,
  lfu_rsp_if.source                  rsp
);

  logic [lfu_pkg::CapW-1:0] capacity_q;
  lfu_pkg::lfu_cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lfu_pkg::CapW'(16);
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  lfu_datapath #(.Entries(Entries)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .capacity_i    (capacity_q),
    .action_i      (req.action),
    .key_i         (req.key),
    .value_i       (req.value),
    .hit_o         (rsp.hit),
    .read_value_o  (rsp.read_value),
    .evicted_o     (rsp.evicted),
    .evicted_key_o (rsp.evicted_key)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready) else $error("request taken while response pending");

  a_rsp_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> ##2 rsp.valid) else $error("response late");

  a_evict_is_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.evicted) |-> !rsp.hit) else $error("eviction on a hit");

endmodule

// ===== test/lfu_cache_with_lru_tiebreak_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache testbench
// Drives random and directed get/put traffic with random stalls on both
// channels, predicts every response in a behavioral cache model and compares
// the responses field by field.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak_test;

  localparam int unsigned Slots = 16;

  typedef struct {
    logic                         action;
    logic [lfu_pkg::KeyW-1:0]     key;
    logic [lfu_pkg::ValW-1:0]     value;
  } request_t;

  typedef struct {
    logic                         hit;
    logic [lfu_pkg::ValW-1:0]     read_value;
    logic                         evicted;
    logic [lfu_pkg::KeyW-1:0]     evicted_key;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lfu_pkg::CapW-1:0] cfg_wdata_i = '0;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_cache_with_lru_tiebreak #(.Entries(Slots)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i), .req(req.sink), .rsp(rsp.source)
  );

  always #2 clk_i = ~clk_i;

  // Cache model state.
  logic [lfu_pkg::CapW-1:0]   model_cap;
  logic                       m_valid [Slots];
  logic [lfu_pkg::KeyW-1:0]   m_key   [Slots];
  logic [lfu_pkg::ValW-1:0]   m_val   [Slots];
  logic [lfu_pkg::CountW-1:0] m_uses  [Slots];
  int unsigned                m_rank  [Slots];
  int unsigned                m_fill;

  request_t  pending_reqs[$];
  response_t expected_rsps[$];
  int errors = 0;
  int sent = 0;
  int send_idle = 0;
  int take_idle = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  function automatic int find_slot(logic [lfu_pkg::KeyW-1:0] k);
    for (int i = 0; i < Slots; i++) if (m_valid[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_rank(int unsigned r);
    for (int i = 0; i < Slots; i++) if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
  endfunction

  function automatic void make_newest(int idx);
    drop_rank(m_rank[idx]);
    m_rank[idx] = m_fill - 1;
    if (m_uses[idx] != lfu_pkg::CountMax) m_uses[idx]++;
  endfunction

  function automatic response_t predict_access(request_t r);
    response_t o;
    int idx, victim, slot;
    int unsigned cap;
    cap = (model_cap > Slots) ? Slots : model_cap;
    idx = find_slot(r.key);
    o.hit = (idx >= 0);
    o.read_value = '0;
    o.evicted = 1'b0;
    o.evicted_key = '0;
    if (r.action == lfu_pkg::ActGet) begin
      if (idx >= 0) begin
        make_newest(idx);
        o.read_value = m_val[idx];
      end else begin
        o.read_value = lfu_pkg::MissValue;
      end
    end else if (cap != 0) begin
      if (idx >= 0) begin
        m_val[idx] = r.value;
        make_newest(idx);
      end else begin
        slot = -1;
        if (m_fill >= cap) begin
          victim = -1;
          for (int i = 0; i < Slots; i++) begin
            if (!m_valid[i]) continue;
            if (victim < 0 || m_uses[i] < m_uses[victim] ||
                (m_uses[i] == m_uses[victim] && m_rank[i] < m_rank[victim]))
              victim = i;
          end
          if (victim >= 0) begin
            m_valid[victim] = 1'b0;
            drop_rank(m_rank[victim]);
            m_fill--;
            o.evicted = 1'b1;
            o.evicted_key = m_key[victim];
            slot = victim;
          end
        end
        if (slot < 0)
          for (int i = 0; i < Slots; i++) if (!m_valid[i]) begin slot = i; break; end
        if (slot >= 0) begin
          m_valid[slot] = 1'b1;
          m_key[slot] = r.key;
          m_val[slot] = r.value;
          m_uses[slot] = 1;
          m_rank[slot] = m_fill;
          m_fill++;
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Driver: one transfer per handshake, predicting when it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.action <= lfu_pkg::ActGet;
      req.key <= '0;
      req.value <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(predict_access(pending_reqs.pop_front()));
        sent++;
      end
      // A request that is waiting stays on the bus unchanged.
      if (!(req.valid && !req.ready)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          req.valid <= 1'b1;
          req.action <= pending_reqs[0].action;
          req.key <= pending_reqs[0].key;
          req.value <= pending_reqs[0].value;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall, counted here once the stimulus asks for it.
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= 300;
  end

  // Monitor.
  always @(posedge clk_i) begin
    response_t e;
    if (rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("response with none expected");
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.hit !== e.hit) report_mismatch("hit");
        if (rsp.read_value !== e.read_value) report_mismatch("read_value");
        if (rsp.evicted !== e.evicted) report_mismatch("evicted");
        if (rsp.evicted_key !== e.evicted_key) report_mismatch("evicted_key");
      end
    end
    rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= take_idle);
  end

  task automatic add_req(logic a, logic [lfu_pkg::KeyW-1:0] k,
                         logic [lfu_pkg::ValW-1:0] v);
    request_t r;
    r.action = a;
    r.key = k;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req.valid)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [lfu_pkg::CapW-1:0] c);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_cap = c;
    @(posedge clk_i);
  endtask

  // Mostly a small key pool so hits, updates and evictions are frequent.
  task automatic random_burst(int n, int pool);
    logic [lfu_pkg::KeyW-1:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(pool - 1);
      if ($urandom_range(9) == 0) k = ~k;
      add_req(1'($urandom_range(1)), k, $urandom());
    end
  endtask

  initial begin
    model_cap = 16;
    m_fill = 0;
    for (int i = 0; i < Slots; i++) begin
      m_valid[i] = 1'b0; m_key[i] = '0; m_val[i] = '0; m_uses[i] = '0; m_rank[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, hits, misses, updates, an eviction tie broken by age.
    send_idle = 25; take_idle = 64;
    add_req(lfu_pkg::ActGet, 32'h8000_0000, '0);
    add_req(lfu_pkg::ActPut, 32'h8000_0000, 32'h7fff_ffff);
    add_req(lfu_pkg::ActPut, 32'h7fff_ffff, 32'h8000_0000);
    add_req(lfu_pkg::ActPut, 32'hffff_ffff, 32'hffff_ffff);
    add_req(lfu_pkg::ActGet, 32'h8000_0000, 32'hffff_ffff);
    add_req(lfu_pkg::ActPut, 32'h7fff_ffff, 32'h0000_0000);
    add_req(lfu_pkg::ActGet, 32'h7fff_ffff, '0);
    add_req(lfu_pkg::ActGet, 32'h0000_0000, '0);
    set_capacity(2);
    add_req(lfu_pkg::ActPut, 32'd5, 32'd50);
    add_req(lfu_pkg::ActPut, 32'd6, 32'd60);
    add_req(lfu_pkg::ActPut, 32'd7, 32'd70);
    add_req(lfu_pkg::ActGet, 32'd6, '0);
    add_req(lfu_pkg::ActPut, 32'd8, 32'd80);
    add_req(lfu_pkg::ActGet, 32'd7, '0);
    set_capacity(0);
    add_req(lfu_pkg::ActPut, 32'd9, 32'd90);
    add_req(lfu_pkg::ActPut, 32'd8, 32'd1);
    add_req(lfu_pkg::ActGet, 32'd8, '0);
    set_capacity(31);
    add_req(lfu_pkg::ActPut, 32'd10, 32'd100);
    add_req(lfu_pkg::ActGet, 32'd10, '0);
    set_capacity(1);
    add_req(lfu_pkg::ActPut, 32'd11, 32'd110);
    add_req(lfu_pkg::ActGet, 32'd11, '0);

    // Receiver holds off while the sender keeps offering.
    set_capacity(16);
    hold_req = 1'b1;
    random_burst(20, 24);
    wait (hold_left != 0);
    hold_req = 1'b0;
    wait (hold_left == 0);

    random_burst(200, 24);
    set_capacity(5);
    send_idle = 64; take_idle = 25;
    random_burst(200, 12);
    set_capacity(17);
    random_burst(150, 40);
    set_capacity(3);
    send_idle = 0; take_idle = 0;
    random_burst(150, 8);
    drain();
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
